// File: hdl/bitmap_slot_allocator_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap slot allocator
// Concurrent checks clocked on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BSA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define BSA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BSA_ASSERT(lbl, cond, msg)
`define BSA_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: hdl/bsa_pkg.sv
// ---------------------------------------------------------------------------
// bsa_pkg
// Shared constants, status codes and helpers of the bitmap slot allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  // Default number of slots.
  localparam int BSA_SLOT_COUNT = 2048;

  // The bitmap is held as rows of sixteen slots.
  localparam int ROW_W = 16;
  localparam int BIT_W = 4;

  // Result status codes.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_FULL         = 2'd1;
  localparam logic [1:0] ST_ALREADY_FREE = 2'd2;
  localparam logic [1:0] ST_RANGE        = 2'd3;

  // Position of the lowest clear bit of a row; only meaningful when one exists.
  function automatic logic [BIT_W-1:0] first_zero(input logic [ROW_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// File: hdl/bitmap_slot_allocator_unit.sv
// ---------------------------------------------------------------------------
// bitmap_slot_allocator_unit
// First-fit slot allocator over a used/free bitmap with a used-slot count.
// ---------------------------------------------------------------------------
// Usage. Requests arrive on the in_ stream: in_tuser carries the operation
// (0 allocate the lowest free slot, 1 free the slot in in_tdata). Each
// request yields exactly one item on the out_ stream carrying the status in
// out_tuser and the allocated slot and used count in out_tdata.
// Sequencing. A request is taken, its bitmap row is read, the row is
// evaluated and written back, and the result is loaded into the output
// register: out_tvalid rises once the result is loaded, and in_tready
// comes back with it, so a new request is taken only after the last one
// has been handed to the output register. An allocate that meets full
// rows walks on one row of sixteen slots at a time, reading each before
// evaluating it; a pointer to the lowest row that may hold a free slot
// keeps that walk short. One request is in flight at a time.
// Reset. After rst_n a clearing pass writes every bitmap row to zero, one
// row a cycle (ceil(SLOT_COUNT/16) rows, 128 by default), and in_tready
// stays low until it is done.
// Stalls. The output register holds its item until out_tready; a new
// request is still taken meanwhile, and its result waits for the register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bitmap_slot_allocator_unit_assert.svh"

module bitmap_slot_allocator_unit
  import bsa_pkg::*;
#(
  parameter int SLOT_COUNT = BSA_SLOT_COUNT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] slot_index, [15:12] zero
  input  wire logic [0:0]  in_tuser,   // [0] op
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [10:0] slot_out, [22:11] used_count, [23] zero
  output logic      [1:0]  out_tuser   // [1:0] status
);

  localparam int ROWS     = (SLOT_COUNT + ROW_W - 1) / ROW_W;
  localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W   = ROW_AW + BIT_W;
  localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
  localparam int LAST_VALID = SLOT_COUNT - (ROWS - 1) * ROW_W;
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
  // Bits of the last row that lie beyond the slot count count as used.
  localparam logic [ROW_W-1:0]  PAD_MASK = ROW_W'(32'h0000FFFF << LAST_VALID);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ROW_AW-1:0] addr_r, addr_nxt;
  logic [ROW_AW-1:0] hint_r, hint_nxt;
  logic [CNT_W-1:0]  used_cnt_r, used_cnt_nxt;
  logic              op_r, op_nxt;
  logic              in_range_r, in_range_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [10:0]       res_slot_r, res_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [23:0]       out_data_r, out_data_nxt;
  logic [1:0]        out_user_r, out_user_nxt;

  logic              map_we;
  logic [ROW_W-1:0]  map_wdata;
  logic [ROW_W-1:0]  map_rdata;
  logic [ROW_W-1:0]  row_bits;
  logic [BIT_W-1:0]  free_pos;
  logic [31:0]       idx_ext;
  logic [31:0]       slot_ext;
  logic [31:0]       cnt_ext;
  logic              accept;

  bsa_map_ram #(
    .ROWS (ROWS),
    .AW   (ROW_AW)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (addr_r),
    .wdata (map_wdata),
    .raddr (addr_r),
    .rdata (map_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign idx_ext  = 32'(in_tdata[11:0]);
  assign row_bits = map_rdata | ((addr_r == LAST_ROW) ? PAD_MASK : '0);
  assign free_pos = first_zero(row_bits);
  assign slot_ext = 32'({addr_r, free_pos});
  assign cnt_ext  = 32'(used_cnt_r);

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    hint_nxt       = hint_r;
    used_cnt_nxt   = used_cnt_r;
    op_nxt         = op_r;
    in_range_nxt   = in_range_r;
    bit_nxt        = bit_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    map_we         = 1'b0;
    map_wdata      = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        // Sweep every row to zero, addr_r doubling as the sweep counter.
        map_we = 1'b1;
        if (addr_r == LAST_ROW) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt       = in_tuser[0];
          in_range_nxt = (idx_ext < SLOT_COUNT);
          bit_nxt      = idx_ext[BIT_W-1:0];
          if (!in_tuser[0]) begin
            addr_nxt = hint_r;
          end else if (idx_ext < SLOT_COUNT) begin
            addr_nxt = idx_ext[SLOT_W-1:BIT_W];
          end else begin
            addr_nxt = '0;
          end
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        res_slot_nxt = '0;
        state_nxt    = S_RESP;
        if (!op_r) begin
          if (row_bits != '1) begin
            map_we         = 1'b1;
            map_wdata      = map_rdata | (ROW_W'(1) << free_pos);
            used_cnt_nxt   = used_cnt_r + 1'b1;
            hint_nxt       = addr_r;
            res_status_nxt = ST_OK;
            res_slot_nxt   = slot_ext[10:0];
          end else if (addr_r == LAST_ROW) begin
            res_status_nxt = ST_FULL;
          end else begin
            // Row is full: move on to the next one.
            addr_nxt  = addr_r + 1'b1;
            state_nxt = S_READ;
          end
        end else begin
          if (!in_range_r) begin
            res_status_nxt = ST_RANGE;
          end else if (!map_rdata[bit_r]) begin
            res_status_nxt = ST_ALREADY_FREE;
          end else begin
            map_we         = 1'b1;
            map_wdata      = map_rdata & ~(ROW_W'(1) << bit_r);
            if (used_cnt_r != '0) begin
              used_cnt_nxt = used_cnt_r - 1'b1;
            end
            if (addr_r < hint_r) begin
              hint_nxt = addr_r;
            end
            res_status_nxt = ST_OK;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, cnt_ext[11:0], res_slot_r};
          out_user_nxt  = res_status_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      hint_r      <= '0;
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      hint_r      <= hint_nxt;
      used_cnt_r  <= used_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    in_range_r   <= in_range_nxt;
    bit_r        <= bit_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  // The count can never exceed the number of slots.
  `BSA_ASSERT(a_cnt_bound, cnt_ext <= SLOT_COUNT, "used count beyond slot count")
  // A successful allocate raises the count by exactly one.
  `BSA_ASSERT_NEXT(a_alloc_cnt, (state_r == S_EVAL) && map_we && !op_r, used_cnt_r == $past(used_cnt_r) + 1'b1, "allocate did not bump the count")
  // No result may appear while the bitmap is still being cleared.
  `BSA_ASSERT(a_clear_quiet, (state_r != S_CLEAR) || !out_valid_r, "result during clearing pass")
  // The free-row pointer always names a real row.
  `BSA_ASSERT(a_hint_bound, hint_r <= LAST_ROW, "search pointer beyond last row")

endmodule

`default_nettype wire

// File: hdl/bsa_map_ram.sv
// ---------------------------------------------------------------------------
// bsa_map_ram
// Single write, single registered read memory holding the used bitmap rows.
// ---------------------------------------------------------------------------
`default_nettype none

module bsa_map_ram
  import bsa_pkg::*;
#(
  parameter int ROWS = 128,
  parameter int AW   = 7
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [ROW_W-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [ROW_W-1:0] rdata
);

  logic [ROW_W-1:0] mem_r [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire
